[rtl/minmax_svpwm_duty_unit_macros.svh]
// ----------------------------------------------------------------------------
// SVPWM duty unit assertion macros
// Assertion macros shared by the checker files of the SVPWM duty unit.
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MINMAX_SVPWM_DUTY_UNIT_MACROS_SVH
`define MINMAX_SVPWM_DUTY_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SVD_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Property checked at every edge, reset included.
`define SVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/svd_pkg.sv]
// ----------------------------------------------------------------------------
// SVPWM duty unit package
// Item types, fixed-point widths and status codes shared by the unit.
// ----------------------------------------------------------------------------
package svd_pkg;

  localparam int LANES = 3;   // phases A, B, C
  localparam int Q_W   = 15;  // quotient bits, enough for 0..16384 plus overflow
  localparam int DEN_W = 18;  // divisor 4 * bus
  localparam int NUM_W = 35;  // rounded numerator |m| + 2 * bus
  localparam int V_W   = 34;  // phase voltages in Q8.8 times 2^16
  localparam int M_W   = 36;  // offset numerator 2 * v - (max + min)

  // sqrt(3)/2 as unsigned Q0.16, rounded to nearest.
  localparam logic [15:0] K_Q16     = 16'd56756;
  localparam logic [15:0] DUTY_HALF = 16'd16384;
  localparam logic [15:0] DUTY_FULL = 16'd32768;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLAMP   = 2'd1;
  localparam logic [1:0] ST_BUS_BAD = 2'd2;

  typedef struct packed {
    logic signed [15:0] alpha_voltage;
    logic signed [15:0] beta_voltage;
    logic        [15:0] bus_voltage;
  } in_item_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [1:0]  status;
  } out_item_t;

  // Front end to divider: rounded magnitudes, their signs and the divisor.
  typedef struct packed {
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]            den;
    logic                        bus_zero;
  } num_item_t;

  // Divider to output stage.
  typedef struct packed {
    logic [LANES-1:0]          neg;
    logic [LANES-1:0]          ovf;
    logic [LANES-1:0][Q_W-1:0] quo;
    logic                      bus_zero;
  } quo_item_t;

endpackage

[rtl/svd_if.sv]
// ----------------------------------------------------------------------------
// SVPWM duty unit channels
// Valid/ready channels for the voltage input and the duty output.
// ----------------------------------------------------------------------------
interface svd_in_if import svd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface svd_out_if import svd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/svd_phase.sv]
// ----------------------------------------------------------------------------
// SVPWM phase front end
// Six stages: K*beta product, phase voltages, max/min, common-mode sum,
// offset numerator, and the rounded numerator and divisor for the divider.
// ----------------------------------------------------------------------------
module svd_phase import svd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output num_item_t out_item
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] go;

  // Stage 1
  logic signed [15:0] alpha1;
  logic        [15:0] bus1;
  logic signed [32:0] kb1;
  // Stage 2
  logic        [15:0]    bus2;
  logic signed [V_W-1:0] v2 [LANES];
  // Stage 3
  logic        [15:0]    bus3;
  logic signed [V_W-1:0] v3 [LANES];
  logic signed [V_W-1:0] vmax3;
  logic signed [V_W-1:0] vmin3;
  // Stage 4
  logic        [15:0]    bus4;
  logic signed [V_W-1:0] v4 [LANES];
  logic signed [V_W:0]   sum4;
  // Stage 5
  logic        [15:0]    bus5;
  logic signed [M_W-1:0] m5 [LANES];

  logic signed [V_W-1:0] va_c;
  logic signed [V_W-1:0] ah_c;
  logic signed [V_W-1:0] kb_c;
  logic signed [V_W-1:0] mx_c;
  logic signed [V_W-1:0] mn_c;
  logic signed [M_W-1:0] two_bus_c;

  // A stage can take new data when it is empty or its successor moves.
  always_comb begin
    go[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  assign in_ready  = go[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (go[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      alpha1 <= in_item.alpha_voltage;
      bus1   <= in_item.bus_voltage;
      kb1    <= in_item.beta_voltage * $signed({1'b0, K_Q16});
    end
  end

  always_comb begin
    va_c = V_W'($signed({alpha1, 16'h0000}));
    ah_c = -V_W'($signed({alpha1, 15'h0000}));
    kb_c = V_W'(kb1);
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      bus2  <= bus1;
      v2[0] <= va_c;
      v2[1] <= ah_c + kb_c;
      v2[2] <= ah_c - kb_c;
    end
  end

  always_comb begin
    mx_c = v2[0];
    mn_c = v2[0];
    for (int i = 1; i < LANES; i++) begin
      if (v2[i] > mx_c) begin
        mx_c = v2[i];
      end
      if (v2[i] < mn_c) begin
        mn_c = v2[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      bus3  <= bus2;
      v3    <= v2;
      vmax3 <= mx_c;
      vmin3 <= mn_c;
    end
  end

  always_ff @(posedge clk) begin
    if (go[3]) begin
      bus4 <= bus3;
      v4   <= v3;
      sum4 <= (V_W + 1)'(vmax3) + (V_W + 1)'(vmin3);
    end
  end

  always_ff @(posedge clk) begin
    if (go[4]) begin
      bus5 <= bus4;
      for (int i = 0; i < LANES; i++) begin
        m5[i] <= M_W'($signed({v4[i], 1'b0})) - M_W'(sum4);
      end
    end
  end

  // Rounding to nearest with ties away from zero: |m| + 2*bus over 4*bus.
  assign two_bus_c = $signed(M_W'({bus5, 1'b0}));

  always_ff @(posedge clk) begin
    if (go[5]) begin
      for (int i = 0; i < LANES; i++) begin
        out_item.neg[i] <= m5[i][M_W-1];
        if (m5[i][M_W-1]) begin
          out_item.num[i] <= NUM_W'(two_bus_c - m5[i]);
        end else begin
          out_item.num[i] <= NUM_W'(m5[i] + two_bus_c);
        end
      end
      out_item.den      <= {bus5, 2'b00};
      out_item.bus_zero <= (bus5 == '0);
    end
  end

endmodule

[rtl/svd_div.sv]
// ----------------------------------------------------------------------------
// SVPWM restoring divider
// Three lanes share one valid chain: an overflow check stage, then one
// quotient bit per stage. Quotients at or above 2^Q_W are flagged instead.
// ----------------------------------------------------------------------------
module svd_div import svd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  num_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output quo_item_t out_item
);

  localparam int NST = Q_W + 1;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   lo;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [DEN_W-1:0]  den;
    logic              bus_zero;
  } stg_t;

  stg_t           stg [NST];
  logic [NST-1:0] vld;
  logic [NST-1:0] go;

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  function automatic lane_t div_step(input lane_t l, input logic [DEN_W-1:0] den);
    lane_t          r;
    logic [DEN_W:0] t;
    logic           ge;
    r     = l;
    t     = {l.rem, l.lo[Q_W-1]};
    ge    = (t >= {1'b0, den});
    r.rem = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
    r.lo  = {l.lo[Q_W-2:0], 1'b0};
    r.quo = {l.quo[Q_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    go[NST-1] = !vld[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  assign in_ready  = go[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (go[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      for (int i = 0; i < LANES; i++) begin
        stg[0].lane[i].ovf <= in_item.num[i] >= NUM_W'({in_item.den, {Q_W{1'b0}}});
        stg[0].lane[i].rem <= in_item.num[i][Q_W +: DEN_W];
        stg[0].lane[i].lo  <= in_item.num[i][Q_W-1:0];
        stg[0].lane[i].quo <= '0;
        stg[0].lane[i].neg <= in_item.neg[i];
      end
      stg[0].den      <= in_item.den;
      stg[0].bus_zero <= in_item.bus_zero;
    end
    for (int k = 1; k < NST; k++) begin
      if (go[k]) begin
        for (int i = 0; i < LANES; i++) begin
          stg[k].lane[i] <= div_step(stg[k-1].lane[i], stg[k-1].den);
        end
        stg[k].den      <= stg[k-1].den;
        stg[k].bus_zero <= stg[k-1].bus_zero;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_item.neg[i] = stg[NST-1].lane[i].neg;
      out_item.ovf[i] = stg[NST-1].lane[i].ovf;
      out_item.quo[i] = stg[NST-1].lane[i].quo;
    end
    out_item.bus_zero = stg[NST-1].bus_zero;
  end

endmodule

[rtl/svd_duty.sv]
// ----------------------------------------------------------------------------
// SVPWM duty output stage
// Adds the signed offset to one half, clamps to 0..1 and sets the status.
// Holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module svd_duty import svd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  quo_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [15:0]      duty_c [LANES];
  logic [LANES-1:0] clamp_c;
  out_item_t        item_c;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      clamp_c[i] = in_item.ovf[i] || (in_item.quo[i] > Q_W'(DUTY_HALF));
      if (clamp_c[i]) begin
        duty_c[i] = in_item.neg[i] ? '0 : DUTY_FULL;
      end else if (in_item.neg[i]) begin
        duty_c[i] = DUTY_HALF - {1'b0, in_item.quo[i]};
      end else begin
        duty_c[i] = DUTY_HALF + {1'b0, in_item.quo[i]};
      end
    end
    if (in_item.bus_zero) begin
      item_c = '{duty_a: '0, duty_b: '0, duty_c: '0, status: ST_BUS_BAD};
    end else begin
      item_c.duty_a = duty_c[0];
      item_c.duty_b = duty_c[1];
      item_c.duty_c = duty_c[2];
      item_c.status = (|clamp_c) ? ST_CLAMP : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= item_c;
    end
  end

endmodule

[rtl/minmax_svpwm_duty_unit.sv]
// ----------------------------------------------------------------------------
// Min-max SVPWM duty unit
// Turns an alpha/beta voltage and the bus voltage into three clamped phase
// duties with min-max zero-sequence injection.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields
// volt     in         alpha_voltage, beta_voltage, bus_voltage
// duty     out        duty_a, duty_b, duty_c, status
//
// One item per cycle is accepted while duty does not stall. The pipeline has
// six front-end stages, the divider's overflow stage plus one stage per quotient
// bit, and the output register. The divider pipeline sets the depth.
// Reset clears the valid bits only; data registers are not reset.
// When duty stalls, items back up stage by stage and empty stages fill in,
// so volt keeps accepting until the whole pipeline is full.
// ----------------------------------------------------------------------------
module minmax_svpwm_duty_unit import svd_pkg::*; (
  input logic      clk,
  input logic      rst,
  svd_in_if.sink   volt,
  svd_out_if.source duty
);

  logic      num_valid;
  logic      num_ready;
  num_item_t num_item;
  logic      quo_valid;
  logic      quo_ready;
  quo_item_t quo_item;

  svd_phase u_phase (
    .clk      (clk),
    .rst      (rst),
    .in_valid (volt.valid),
    .in_ready (volt.ready),
    .in_item  (volt.payload),
    .out_valid(num_valid),
    .out_ready(num_ready),
    .out_item (num_item)
  );

  svd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (num_valid),
    .in_ready (num_ready),
    .in_item  (num_item),
    .out_valid(quo_valid),
    .out_ready(quo_ready),
    .out_item (quo_item)
  );

  svd_duty u_duty (
    .clk      (clk),
    .rst      (rst),
    .in_valid (quo_valid),
    .in_ready (quo_ready),
    .in_item  (quo_item),
    .out_valid(duty.valid),
    .out_ready(duty.ready),
    .out_item (duty.payload)
  );

endmodule

[rtl/svd_chk.sv]
// ----------------------------------------------------------------------------
// SVPWM duty unit checker
// Port-level assertions on the duty channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "minmax_svpwm_duty_unit_macros.svh"

module svd_chk import svd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  `SVD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "duty item changed while stalled")
  `SVD_ASSERT_IMPL(a_bad_bus_zero, out_valid && out_item.status == ST_BUS_BAD, out_item.duty_a == '0 && out_item.duty_b == '0 && out_item.duty_c == '0, "invalid bus item with nonzero duty")
  `SVD_ASSERT_IMPL(a_duty_range, out_valid, out_item.duty_a <= DUTY_FULL && out_item.duty_b <= DUTY_FULL && out_item.duty_c <= DUTY_FULL, "duty above full scale")
  `SVD_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "duty item present right after reset")

endmodule

bind minmax_svpwm_duty_unit svd_chk u_svd_chk (
  .clk      (clk),
  .rst      (rst),
  .out_valid(duty.valid),
  .out_ready(duty.ready),
  .out_item (duty.payload)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Min-max SVPWM duty unit testbench
// Sends alpha/beta/bus voltage items through the valid/ready input with
// bursty timing while the duty output stalls on its own pattern. Each
// accepted item is run through a local fixed-point model of the min-max
// injection, and every returned duty item is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import svd_pkg::*;

  logic clk;
  logic rst;

  svd_in_if  volt ();
  svd_out_if duty ();

  minmax_svpwm_duty_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .volt (volt.sink),
    .duty (duty.source)
  );

  out_item_t duty_expect_q[$];
  int        mismatch_count = 0;
  int        burst_left     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Expected duties for one voltage item. Phase voltages are kept in Q8.8
  // times 2^16 so that the offset numerator is exact.
  function automatic out_item_t predict_duties(in_item_t v);
    longint    alpha;
    longint    beta;
    longint    bus;
    longint    k;
    longint    ph[3];
    longint    vmax;
    longint    vmin;
    longint    den;
    longint    m;
    longint    mag;
    longint    q;
    longint    d;
    bit        clamped;
    logic [15:0] lane[3];
    out_item_t r;
    alpha   = longint'(v.alpha_voltage);
    beta    = longint'(v.beta_voltage);
    bus     = longint'(v.bus_voltage);
    k       = longint'(K_Q16);
    clamped = 1'b0;
    if (bus == 0) begin
      r.duty_a = '0;
      r.duty_b = '0;
      r.duty_c = '0;
      r.status = ST_BUS_BAD;
      return r;
    end
    ph[0] = alpha * 65536;
    ph[1] = -alpha * 32768 + k * beta;
    ph[2] = -alpha * 32768 - k * beta;
    vmax = ph[0];
    vmin = ph[0];
    for (int i = 1; i < 3; i++) begin
      if (ph[i] > vmax) vmax = ph[i];
      if (ph[i] < vmin) vmin = ph[i];
    end
    den = 4 * bus;
    for (int i = 0; i < 3; i++) begin
      m   = 2 * ph[i] - (vmax + vmin);
      mag = (m < 0) ? -m : m;
      // Round to nearest, ties away from zero.
      q   = (mag + den / 2) / den;
      d   = longint'(DUTY_HALF) + ((m < 0) ? -q : q);
      if (d < 0) begin
        d       = 0;
        clamped = 1'b1;
      end else if (d > longint'(DUTY_FULL)) begin
        d       = longint'(DUTY_FULL);
        clamped = 1'b1;
      end
      lane[i] = d[15:0];
    end
    r.duty_a = lane[0];
    r.duty_b = lane[1];
    r.duty_c = lane[2];
    r.status = clamped ? ST_CLAMP : ST_OK;
    return r;
  endfunction

  function automatic in_item_t make_volt(int alpha, int beta, int bus);
    in_item_t v;
    v.alpha_voltage = alpha[15:0];
    v.beta_voltage  = beta[15:0];
    v.bus_voltage   = bus[15:0];
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Sends one item; between bursts the sender may drop valid for a random gap.
  task automatic send_volt(in_item_t v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        volt.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    volt.valid   <= 1'b1;
    volt.payload <= v;
    do @(posedge clk); while (!volt.ready);
    duty_expect_q.push_back(predict_duties(v));
  endtask

  task automatic wait_drained();
    volt.valid <= 1'b0;
    burst_left = 0;
    while (duty_expect_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: switches between always ready, scattered stalls and long stalls.
  initial begin
    int mode;
    int mode_left;
    int stall_left;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    duty.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        0: duty.ready <= 1'b1;
        1: duty.ready <= ($urandom_range(3) != 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            duty.ready <= 1'b0;
          end else begin
            if ($urandom_range(7) == 0) stall_left = $urandom_range(1, 40);
            duty.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && duty.valid && duty.ready) begin
      if (duty_expect_q.size() == 0) begin
        report_mismatch("duty item with no voltage item outstanding");
      end else begin
        want = duty_expect_q.pop_front();
        check_field("duty_a", duty.payload.duty_a, want.duty_a);
        check_field("duty_b", duty.payload.duty_b, want.duty_b);
        check_field("duty_c", duty.payload.duty_c, want.duty_c);
        check_field("status", duty.payload.status, want.status);
      end
    end
  end

  task automatic test_invalid_bus();
    send_volt(make_volt(0, 0, 0));
    send_volt(make_volt(32767, -32768, 0));
    send_volt(make_volt(-32768, 32767, 0));
  endtask

  task automatic test_field_extremes();
    int alphas[2] = '{-32768, 32767};
    int betas[2]  = '{-32768, 32767};
    int buses[2]  = '{1, 65535};
    foreach (alphas[i])
      foreach (betas[j])
        foreach (buses[n])
          send_volt(make_volt(alphas[i], betas[j], buses[n]));
    send_volt(make_volt(0, 0, 65535));
    send_volt(make_volt(0, 0, 1));
  endtask

  // Offsets of exactly one half in both directions, plus a plain in-range case.
  task automatic test_rounding();
    send_volt(make_volt(1, 0, 16384));
    send_volt(make_volt(-1, 0, 16384));
    send_volt(make_volt(16'h1000, 16'h0800, 16'h3000));
  endtask

  task automatic test_random_traffic(int count);
    int kind;
    int bus;
    int lim;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      kind = $urandom_range(99);
      if (kind < 40) begin
        send_volt(make_volt($urandom, $urandom, $urandom));
      end else if (kind < 70) begin
        bus = $urandom_range(256, 65535);
        lim = (bus / 2 > 32767) ? 32767 : bus / 2;
        send_volt(make_volt(int'($urandom_range(2 * lim)) - lim,
                            int'($urandom_range(2 * lim)) - lim, bus));
      end else if (kind < 85) begin
        send_volt(make_volt($urandom, $urandom, $urandom_range(1, 16)));
      end else if (kind < 95) begin
        send_volt(make_volt(int'($urandom_range(16)) - 8,
                            int'($urandom_range(16)) - 8, $urandom_range(1, 4)));
      end else begin
        send_volt(make_volt($urandom, $urandom, 0));
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    volt.valid   <= 1'b0;
    volt.payload <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_invalid_bus();
    test_field_extremes();
    test_rounding();
    test_random_traffic(2000);
    wait_drained();
    repeat (30) @(posedge clk);
    if (duty_expect_q.size() != 0) report_mismatch("voltage items left without duty");
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
